// File: hdl/pfba_pkg.sv
// Shared constants, types and helpers of the page frame bitmap allocator.
package pfba_pkg;

    // Bitmap geometry
    localparam int NUM_FRAMES      = 32768;
    localparam int RESERVED_FRAMES = 256;
    localparam int WORD_BITS       = 32;
    localparam int WORD_COUNT      = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW         = $clog2(WORD_COUNT);
    localparam int BIT_AW          = $clog2(WORD_BITS);
    localparam int FRAME_AW        = WORD_AW + BIT_AW;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 15;
    localparam int LEN_W   = 16;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 16;

    // Scan limit and working widths for sums of frames and lengths
    localparam int LIM_W = $clog2(NUM_FRAMES + 1);
    localparam int SUM_W = ((LEN_W > LIM_W) ? LEN_W : LIM_W) + 1;
    localparam int ACC_W = COUNT_W + 1;

    // Reset values
    localparam int RESV_EFF           = (RESERVED_FRAMES < NUM_FRAMES) ?
                                        RESERVED_FRAMES : NUM_FRAMES;
    localparam int USED_RESET         = (RESV_EFF > 65535) ? 65535 : RESV_EFF;
    localparam int FRAMES_TOTAL_RESET = 32768;

    // Configuration port
    localparam int   APB_AW               = 3;
    localparam int   APB_DW               = 32;
    localparam int   REG_SEL_BIT          = 2;
    localparam logic REG_IDX_FRAMES_TOTAL = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC_ONE = 2'd0,
        KIND_FREE_ONE  = 2'd1,
        KIND_ALLOC_RUN = 2'd2,
        KIND_FREE_RUN  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_DONE
    } t_state;

    // Control from the sequencer to the run scanner
    typedef struct packed {
        logic clear;
        logic step;
    } t_scan_ctl;

    // Reset contents of one bitmap word: reserved low frames marked used
    function automatic logic [WORD_BITS-1:0] init_word(input logic [WORD_AW-1:0] w);
        logic [WORD_BITS-1:0] word;
        logic [31:0]          frame;
        word = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            frame   = 32'({w, BIT_AW'(b)});
            word[b] = (frame < 32'(RESV_EFF));
        end
        return word;
    endfunction

endpackage

// File: hdl/pfba_req_if.sv
// Request channel of the page frame bitmap allocator.
interface pfba_req_if;
    import pfba_pkg::*;

    logic                valid;
    logic                ready;
    t_kind               kind;
    logic [INDEX_W-1:0]  frame_index;
    logic [LEN_W-1:0]    run_length;

    modport source (output valid, output kind, output frame_index, output run_length,
                    input ready);
    modport sink   (input valid, input kind, input frame_index, input run_length,
                    output ready);
endinterface

// File: hdl/pfba_rsp_if.sv
// Response channel of the page frame bitmap allocator.
interface pfba_rsp_if;
    import pfba_pkg::*;

    logic                valid;
    logic                ready;
    logic                ok;
    logic [INDEX_W-1:0]  first_frame;
    logic [COUNT_W-1:0]  used_total;

    modport source (output valid, output ok, output first_frame, output used_total,
                    input ready);
    modport sink   (input valid, input ok, input first_frame, input used_total,
                    output ready);
endinterface

// File: hdl/pfba_run_scan.sv
// Run scanner: tests one bitmap word per step against the wanted run length.
module pfba_run_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfba_pkg::t_scan_ctl           i_ctl,
    input  logic [pfba_pkg::WORD_BITS-1:0] i_free,
    input  logic [pfba_pkg::LEN_W-1:0]     i_len,
    output logic                          o_hit,
    output logic [pfba_pkg::BIT_AW-1:0]    o_pos
);
    import pfba_pkg::*;

    logic [LIM_W-1:0]     r_carry;
    logic [LIM_W-1:0]     n_carry;
    logic [WORD_BITS-1:0] cond;
    logic [WORD_BITS-1:0] cond_first;
    logic [WORD_BITS-1:0] used_rev;
    logic [WORD_BITS-1:0] used_rev_first;
    logic [BIT_AW-1:0]    top_run;

    // Per bit: does a run of i_len free frames end here?
    always_comb begin
        logic [SUM_W-1:0]     diff;
        logic [BIT_AW-1:0]    lo;
        logic [WORD_BITS-1:0] win;
        for (int p = 0; p < WORD_BITS; p++) begin
            diff = SUM_W'(p + 1) - SUM_W'(i_len);
            lo   = (SUM_W'(i_len) <= SUM_W'(p + 1)) ? diff[BIT_AW-1:0] : '0;
            win  = ({WORD_BITS{1'b1}} << lo) &
                   ({WORD_BITS{1'b1}} >> BIT_AW'(WORD_BITS - 1 - p));
            cond[p] = ((~i_free & win) == '0) &&
                      ((SUM_W'(r_carry) + SUM_W'(p + 1)) >= SUM_W'(i_len));
        end
    end

    // Pick the lowest position that completes the run
    assign cond_first = cond & (~cond + WORD_BITS'(1));

    always_comb begin
        o_pos = '0;
        for (int p = 0; p < WORD_BITS; p++) begin
            if (cond_first[p]) begin
                o_pos = o_pos | BIT_AW'(p);
            end
        end
    end

    assign o_hit = |cond;

    // Count free frames at the top of the word to carry into the next one
    always_comb begin
        for (int q = 0; q < WORD_BITS; q++) begin
            used_rev[q] = ~i_free[WORD_BITS - 1 - q];
        end
    end

    assign used_rev_first = used_rev & (~used_rev + WORD_BITS'(1));

    always_comb begin
        top_run = '0;
        for (int q = 0; q < WORD_BITS; q++) begin
            if (used_rev_first[q]) begin
                top_run = top_run | BIT_AW'(q);
            end
        end
    end

    assign n_carry = (&i_free) ? (r_carry + LIM_W'(WORD_BITS)) : LIM_W'(top_run);

    // Hold the running count of free frames across words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
        end else if (i_ctl.clear) begin
            r_carry <= '0;
        end else if (i_ctl.step) begin
            r_carry <= n_carry;
        end
    end

endmodule

// File: hdl/page_frame_bitmap_allocator.sv
// Top level of the page frame bitmap allocator: sequencer, bitmap memory, config port.
//
// Requests arrive on i_req (valid/ready): allocate one frame, free one frame,
// allocate a run or free a run. Each request gives one response on o_rsp with
// ok, first_frame and the used frame count after the request. frames_total is
// written through the APB-style port at byte address 0 (read back there too).
// The bitmap sits in a single-port-write, registered-read memory of 32-bit
// words; one word is read, tested or updated per cycle. An allocation scans
// words until a run of free frames completes and then marks that run's words;
// a failed allocation stops at the last word below the limit, or goes straight
// to the response if it fails on decode. A free clears the freed frames in the
// words that they span, or goes straight to the response if nothing is freed.
// Requests are handled one at a time; i_req.ready is high only while idle.
// After reset a sweep over all 1024 bitmap words loads the reserved frames
// into the bitmap, with i_req.ready low; configuration writes are taken meanwhile.
// The response sits in an output register, so the next request is accepted
// while it waits; a request only stalls when it finishes and that register
// is still full.
module page_frame_bitmap_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pfba_req_if.sink                      i_req,
    pfba_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pfba_pkg::APB_AW-1:0]   paddr,
    input  logic [pfba_pkg::APB_DW-1:0]   pwdata,
    output logic [pfba_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import pfba_pkg::*;

    // Sequencer state
    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_frames_total;
    logic [WORD_AW-1:0]   r_addr, n_addr;
    logic [WORD_AW-1:0]   r_last, n_last;
    logic [WORD_AW-1:0]   r_rd_word;
    logic                 r_rd_valid, n_rd_valid;
    logic                 r_issue_done, n_issue_done;
    logic [COUNT_W-1:0]   r_used, n_used;
    logic                 r_out_valid, n_out_valid;

    // Request working registers
    logic [LEN_W-1:0]     r_len, n_len;
    logic [FRAME_AW-1:0]  r_lim_m1, n_lim_m1;
    logic [FRAME_AW-1:0]  r_lo, n_lo;
    logic [FRAME_AW-1:0]  r_hi, n_hi;
    logic [LEN_W-1:0]     r_cnt, n_cnt;
    logic                 r_set, n_set;
    logic                 r_ok, n_ok;
    logic [INDEX_W-1:0]   r_first, n_first;
    logic                 r_out_ok, n_out_ok;
    logic [INDEX_W-1:0]   r_out_first, n_out_first;
    logic [COUNT_W-1:0]   r_out_used, n_out_used;

    // Bitmap memory
    logic [WORD_BITS-1:0] r_bitmap [WORD_COUNT];
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 mem_we;
    logic [WORD_AW-1:0]   mem_wa;
    logic [WORD_BITS-1:0] mem_wd;

    // Scanner link
    t_scan_ctl            scan_ctl;
    logic [WORD_BITS-1:0] scan_free;
    logic                 scan_hit;
    logic [BIT_AW-1:0]    scan_pos;

    // Request decode
    logic                 req_take;
    logic                 req_alloc;
    logic [LEN_W-1:0]     acc_len;
    logic [LIM_W-1:0]     lim;
    logic [SUM_W-1:0]     lim_ext, len_ext, idx_ext, room, freed;
    logic [FRAME_AW-1:0]  lim_m1, free_hi;
    logic                 alloc_fail, free_none;

    // Word datapath
    logic [WORD_BITS-1:0] last_mask;
    logic [FRAME_AW-1:0]  hit_end, hit_start;
    logic [BIT_AW-1:0]    lo_off, hi_off;
    logic [WORD_BITS-1:0] mark_mask;
    logic [ACC_W-1:0]     used_sum;
    logic [COUNT_W-1:0]   used_next;
    logic                 cfg_wr;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr[REG_SEL_BIT] == REG_IDX_FRAMES_TOTAL);
    assign prdata = (paddr[REG_SEL_BIT] == REG_IDX_FRAMES_TOTAL) ?
                    APB_DW'(r_frames_total) : '0;

    // Handshakes and response payload
    assign i_req.ready       = (r_state == ST_IDLE);
    assign req_take          = i_req.valid && i_req.ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_out_ok;
    assign o_rsp.first_frame = r_out_first;
    assign o_rsp.used_total  = r_out_used;

    // Decode the offered request against the scan limit
    assign req_alloc  = (i_req.kind == KIND_ALLOC_ONE) || (i_req.kind == KIND_ALLOC_RUN);
    assign acc_len    = ((i_req.kind == KIND_ALLOC_ONE) || (i_req.kind == KIND_FREE_ONE)) ?
                        LEN_W'(1) : i_req.run_length;
    assign lim        = (32'(r_frames_total) < 32'(NUM_FRAMES)) ?
                        LIM_W'(r_frames_total) : LIM_W'(NUM_FRAMES);
    assign lim_ext    = SUM_W'(lim);
    assign len_ext    = SUM_W'(acc_len);
    assign idx_ext    = SUM_W'(i_req.frame_index);
    assign lim_m1     = FRAME_AW'(lim_ext - SUM_W'(1));
    assign alloc_fail = (acc_len == '0) || (lim == '0) || (len_ext > lim_ext);
    assign free_none  = (acc_len == '0) || (idx_ext >= lim_ext);
    assign room       = lim_ext - idx_ext;
    assign freed      = (len_ext < room) ? len_ext : room;
    assign free_hi    = FRAME_AW'(idx_ext + freed - SUM_W'(1));

    // Treat frames at or beyond the limit as used in the last scanned word
    assign last_mask = (r_rd_word == r_last) ?
                       ({WORD_BITS{1'b1}} >>
                        (BIT_AW'(WORD_BITS - 1) - r_lim_m1[BIT_AW-1:0])) :
                       {WORD_BITS{1'b1}};
    assign scan_free = ~r_rd_data & last_mask;

    assign scan_ctl.clear = (r_state == ST_IDLE);
    assign scan_ctl.step  = (r_state == ST_SCAN) && r_rd_valid && !scan_hit;

    pfba_run_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_free  (scan_free),
        .i_len   (r_len),
        .o_hit   (scan_hit),
        .o_pos   (scan_pos)
    );

    // Run start from the frame where the run completes
    assign hit_end   = {r_rd_word, scan_pos};
    assign hit_start = FRAME_AW'(SUM_W'(hit_end) + SUM_W'(1) - SUM_W'(r_len));

    // Bits of the current word that fall inside the marked range
    assign lo_off    = (r_rd_word == r_lo[FRAME_AW-1:BIT_AW]) ? r_lo[BIT_AW-1:0] : '0;
    assign hi_off    = (r_rd_word == r_hi[FRAME_AW-1:BIT_AW]) ?
                       r_hi[BIT_AW-1:0] : BIT_AW'(WORD_BITS - 1);
    assign mark_mask = ({WORD_BITS{1'b1}} << lo_off) &
                       ({WORD_BITS{1'b1}} >> (BIT_AW'(WORD_BITS - 1) - hi_off));

    // Saturating update of the used count
    assign used_sum  = ACC_W'(r_used) + ACC_W'(r_cnt);
    always_comb begin
        if (r_set) begin
            used_next = used_sum[COUNT_W] ? {COUNT_W{1'b1}} : used_sum[COUNT_W-1:0];
        end else begin
            used_next = (COUNT_W'(r_cnt) > r_used) ? '0 : (r_used - COUNT_W'(r_cnt));
        end
    end

    // Sequencer: next state, memory port and working registers
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_last       = r_last;
        n_rd_valid   = 1'b0;
        n_issue_done = r_issue_done;
        n_used       = r_used;
        n_len        = r_len;
        n_lim_m1     = r_lim_m1;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_cnt        = r_cnt;
        n_set        = r_set;
        n_ok         = r_ok;
        n_first      = r_first;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_ok     = r_out_ok;
        n_out_first  = r_out_first;
        n_out_used   = r_out_used;
        mem_we       = 1'b0;
        mem_wa       = r_rd_word;
        mem_wd       = r_rd_data;

        unique case (r_state)
            ST_INIT: begin
                // Load the reset contents, one word a cycle
                mem_we = 1'b1;
                mem_wa = r_addr;
                mem_wd = init_word(r_addr);
                n_addr = r_addr + WORD_AW'(1);
                if (r_addr == WORD_AW'(WORD_COUNT - 1)) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (req_take) begin
                    n_len        = acc_len;
                    n_addr       = '0;
                    n_issue_done = 1'b0;
                    if (req_alloc) begin
                        n_set = 1'b1;
                        if (alloc_fail) begin
                            n_ok    = 1'b0;
                            n_first = '0;
                            n_cnt   = '0;
                            n_state = ST_DONE;
                        end else begin
                            n_lim_m1 = lim_m1;
                            n_last   = lim_m1[FRAME_AW-1:BIT_AW];
                            n_state  = ST_SCAN;
                        end
                    end else begin
                        n_set   = 1'b0;
                        n_ok    = 1'b1;
                        n_first = '0;
                        if (free_none) begin
                            n_cnt   = '0;
                            n_state = ST_DONE;
                        end else begin
                            n_lo    = FRAME_AW'(idx_ext);
                            n_hi    = free_hi;
                            n_cnt   = LEN_W'(freed);
                            n_addr  = idx_ext[FRAME_AW-1:BIT_AW];
                            n_last  = free_hi[FRAME_AW-1:BIT_AW];
                            n_state = ST_MARK;
                        end
                    end
                end
            end

            ST_SCAN: begin
                // Issue the next word read while the previous word is tested
                if (!r_issue_done) begin
                    n_rd_valid = 1'b1;
                    n_addr     = r_addr + WORD_AW'(1);
                    if (r_addr == r_last) begin
                        n_issue_done = 1'b1;
                    end
                end
                if (r_rd_valid) begin
                    if (scan_hit) begin
                        n_ok         = 1'b1;
                        n_first      = INDEX_W'(hit_start);
                        n_lo         = hit_start;
                        n_hi         = hit_end;
                        n_cnt        = r_len;
                        n_addr       = hit_start[FRAME_AW-1:BIT_AW];
                        n_last       = r_rd_word;
                        n_issue_done = 1'b0;
                        n_rd_valid   = 1'b0;
                        n_state      = ST_MARK;
                    end else if (r_rd_word == r_last) begin
                        n_ok       = 1'b0;
                        n_first    = '0;
                        n_cnt      = '0;
                        n_rd_valid = 1'b0;
                        n_state    = ST_DONE;
                    end
                end
            end

            ST_MARK: begin
                // Read, modify and write back each word of the range
                if (!r_issue_done) begin
                    n_rd_valid = 1'b1;
                    n_addr     = r_addr + WORD_AW'(1);
                    if (r_addr == r_last) begin
                        n_issue_done = 1'b1;
                    end
                end
                if (r_rd_valid) begin
                    mem_we = 1'b1;
                    mem_wa = r_rd_word;
                    mem_wd = r_set ? (r_rd_data | mark_mask) : (r_rd_data & ~mark_mask);
                    if (r_rd_word == r_last) begin
                        n_rd_valid = 1'b0;
                        n_state    = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                // Hand over the response once the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_used      = used_next;
                    n_out_valid = 1'b1;
                    n_out_ok    = r_ok;
                    n_out_first = r_first;
                    n_out_used  = used_next;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_INIT;
            r_frames_total <= CFG_W'(FRAMES_TOTAL_RESET);
            r_addr         <= '0;
            r_last         <= '0;
            r_rd_valid     <= 1'b0;
            r_issue_done   <= 1'b1;
            r_used         <= COUNT_W'(USED_RESET);
            r_out_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_last       <= n_last;
            r_rd_valid   <= n_rd_valid;
            r_issue_done <= n_issue_done;
            r_used       <= n_used;
            r_out_valid  <= n_out_valid;
            if (cfg_wr) begin
                r_frames_total <= pwdata[CFG_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_word   <= r_addr;
        r_len       <= n_len;
        r_lim_m1    <= n_lim_m1;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_cnt       <= n_cnt;
        r_set       <= n_set;
        r_ok        <= n_ok;
        r_first     <= n_first;
        r_out_ok    <= n_out_ok;
        r_out_first <= n_out_first;
        r_out_used  <= n_out_used;
    end

    // Bitmap memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_bitmap[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_bitmap[r_addr];
    end

endmodule

// File: hdl/pfba_checker.sv
// Port checks for the page frame bitmap allocator and their binding.
module pfba_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic                          i_rsp_ok,
    input logic [pfba_pkg::INDEX_W-1:0]  i_rsp_first_frame,
    input logic [pfba_pkg::COUNT_W-1:0]  i_rsp_used_total
);
    import pfba_pkg::*;

    // Reset empties the output and stops requests
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_rsp_valid && !i_req_ready))
        else $error("response or ready seen right after reset");

    // The bitmap load after reset keeps requests out
    a_init_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_req_ready)
        else $error("request taken during the bitmap load");

    // One request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("second request taken while one is in progress");

    // A failed allocation reports frame zero
    a_fail_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ok) |-> (i_rsp_first_frame == '0))
        else $error("failed allocation with a non-zero frame");

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_rsp_ok) && $stable(i_rsp_first_frame) &&
         $stable(i_rsp_used_total)))
        else $error("stalled response changed or dropped");

endmodule

bind page_frame_bitmap_allocator pfba_checker u_pfba_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_ok          (o_rsp.ok),
    .i_rsp_first_frame (o_rsp.first_frame),
    .i_rsp_used_total  (o_rsp.used_total)
);

// File: verif/pfba_outcome_checker.sv
// Outcome checker of the page frame bitmap allocator: tracks the bitmap and compares responses.
module pfba_outcome_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pfba_req_if                         req,
    pfba_rsp_if                         rsp,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [pfba_pkg::APB_AW-1:0] i_paddr,
    input  logic [pfba_pkg::APB_DW-1:0] i_pwdata,
    input  logic                        i_pready,
    output int                          o_mismatch_count,
    output int                          o_pending,
    output int                          o_checked
);
    import pfba_pkg::*;

    localparam int unsigned COUNT_LIMIT = 65535;

    typedef struct packed {
        logic               ok;
        logic [INDEX_W-1:0] first_frame;
        logic [COUNT_W-1:0] used_total;
    } t_outcome;

    // Own copy of the allocator state
    bit [NUM_FRAMES-1:0] frame_in_use;
    int unsigned         frames_held;
    logic [CFG_W-1:0]    frames_total_cfg;

    t_outcome outcome_q[$];
    int       mismatches;
    int       checked;

    // Serve one request on the model copy and return its outcome
    function automatic t_outcome serve_request(input t_kind kind,
                                               input logic [INDEX_W-1:0] idx,
                                               input logic [LEN_W-1:0] len_in);
        t_outcome    res;
        int unsigned lim;
        int unsigned len;
        int unsigned run;
        int unsigned start;
        int unsigned freed;
        bit          found;
        lim = (frames_total_cfg < NUM_FRAMES) ? frames_total_cfg : NUM_FRAMES;
        len = (kind == KIND_ALLOC_ONE || kind == KIND_FREE_ONE) ? 1 : len_in;
        res.ok          = 1'b1;
        res.first_frame = '0;
        if (kind == KIND_ALLOC_ONE || kind == KIND_ALLOC_RUN) begin
            // First fit: lowest run of len free frames below the limit
            found = 1'b0;
            run   = 0;
            start = 0;
            if (len != 0) begin
                for (int unsigned i = 0; i < lim && !found; i++) begin
                    if (frame_in_use[i]) begin
                        run = 0;
                    end else begin
                        if (run == 0) start = i;
                        run++;
                        if (run >= len) found = 1'b1;
                    end
                end
            end
            if (found) begin
                for (int unsigned i = start; i < start + len; i++) frame_in_use[i] = 1'b1;
                frames_held = (frames_held + len > COUNT_LIMIT) ? COUNT_LIMIT
                                                                : frames_held + len;
                res.first_frame = INDEX_W'(start);
            end else begin
                res.ok = 1'b0;
            end
        end else begin
            // Clear frames up to the limit; the count drops even for free frames
            freed = 0;
            for (int unsigned i = 0; i < len && idx + i < lim; i++) begin
                frame_in_use[idx + i] = 1'b0;
                freed++;
            end
            frames_held = (freed > frames_held) ? 0 : frames_held - freed;
        end
        res.used_total = COUNT_W'(frames_held);
        return res;
    endfunction

    // Snoop config writes, check response transfers, predict request transfers
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            frame_in_use = '0;
            for (int i = 0; i < RESV_EFF; i++) frame_in_use[i] = 1'b1;
            frames_held      = USED_RESET;
            frames_total_cfg = CFG_W'(FRAMES_TOTAL_RESET);
            outcome_q.delete();
            mismatches = 0;
            checked    = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                (i_paddr >> REG_SEL_BIT) == APB_AW'(REG_IDX_FRAMES_TOTAL)) begin
                frames_total_cfg = i_pwdata[CFG_W-1:0];
            end
            if (rsp.valid && rsp.ready) begin
                if (outcome_q.size() == 0) begin
                    $error("response transfer with no request outstanding");
                    mismatches++;
                end else begin
                    want = outcome_q.pop_front();
                    checked++;
                    if (rsp.ok !== want.ok) begin
                        $error("ok mismatch: expected %0d, actual %0d", want.ok, rsp.ok);
                        mismatches++;
                    end
                    if (rsp.first_frame !== want.first_frame) begin
                        $error("first_frame mismatch: expected %0d, actual %0d",
                               want.first_frame, rsp.first_frame);
                        mismatches++;
                    end
                    if (rsp.used_total !== want.used_total) begin
                        $error("used_total mismatch: expected %0d, actual %0d",
                               want.used_total, rsp.used_total);
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready) begin
                outcome_q.push_back(serve_request(req.kind, req.frame_index, req.run_length));
            end
        end
        o_mismatch_count <= mismatches;
        o_pending        <= outcome_q.size();
        o_checked        <= checked;
    end

endmodule

// File: verif/page_frame_bitmap_allocator_tb.sv
// Testbench top of the page frame bitmap allocator: stimulus, idling and verdict.
module page_frame_bitmap_allocator_tb;
    import pfba_pkg::*;

    localparam int CYCLE_LIMIT  = 8_000_000;
    localparam int DRAIN_CYCLES = 2100;
    localparam int PHASE_ITEMS  = 58;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int         mismatch_count;
    int         pending;
    int         checked;
    int         cycle_count;
    int         request_count;
    int         setting_count;
    t_idle_mode idle_mode;

    pfba_req_if req_if ();
    pfba_rsp_if rsp_if ();

    page_frame_bitmap_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pfba_outcome_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .req              (req_if),
        .rsp              (rsp_if),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_pready         (pready),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stall the response side according to the idling phase
    always @(negedge i_clk) begin
        case (idle_mode)
            IDLE_RECEIVER: rsp_if.ready <= ($urandom_range(0, 99) >= 69);
            IDLE_BOTH:     rsp_if.ready <= ($urandom_range(0, 99) >= 12);
            default:       rsp_if.ready <= 1'b1;
        endcase
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL page_frame_bitmap_allocator");
        $finish;
    end

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 69;
            IDLE_BOTH:   return $urandom_range(0, 99) < 12;
            default:     return 1'b0;
        endcase
    endfunction

    // Present one request and hold it until its transfer
    task automatic send_request(input t_kind kind, input logic [INDEX_W-1:0] idx,
                                input logic [LEN_W-1:0] len);
        @(negedge i_clk);
        while (sender_idles()) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.kind        <= kind;
        req_if.frame_index <= idx;
        req_if.run_length  <= len;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        request_count++;
    endtask

    // Drop valid and hold off until every outstanding response has arrived
    task automatic drain_responses();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Write frames_total over the APB port while the block is idle
    task automatic set_frames_total(input logic [CFG_W-1:0] value);
        drain_responses();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(REG_IDX_FRAMES_TOTAL) << REG_SEL_BIT;
        pwdata  <= {(APB_DW - CFG_W)'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        setting_count++;
    endtask

    // Random request, biased towards frames below the scan limit
    task automatic send_random_request(input int unsigned lim);
        int unsigned      pick;
        int unsigned      span;
        t_kind            kind;
        logic [LEN_W-1:0] len;
        logic [INDEX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 40)      kind = KIND_ALLOC_ONE;
        else if (pick < 65) kind = KIND_ALLOC_RUN;
        else if (pick < 80) kind = KIND_FREE_ONE;
        else                kind = KIND_FREE_RUN;
        pick = $urandom_range(0, 99);
        if (pick < 3)       len = '0;
        else if (pick < 80) len = LEN_W'($urandom_range(1, 16));
        else if (pick < 93) len = LEN_W'($urandom_range(17, 256));
        else                len = LEN_W'($urandom_range(0, 65535));
        span = (lim == 0) ? 64 : ((lim < 1024) ? lim : 1024);
        if ($urandom_range(0, 99) < 85) idx = INDEX_W'($urandom_range(0, span - 1));
        else                            idx = INDEX_W'($urandom_range(0, 32767));
        send_request(kind, idx, len);
    endtask

    initial begin
        int unsigned phase_totals[10];
        int          rand_count;
        phase_totals = '{32768, 300, 1, 64, 1000, 65535, 0, 4096, 40000, 33};

        // Drive every input from time zero and hold reset
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_if.valid       = 1'b0;
        req_if.kind        = KIND_ALLOC_ONE;
        req_if.frame_index = '0;
        req_if.run_length  = '0;
        rsp_if.ready       = 1'b0;
        idle_mode          = IDLE_NONE;
        request_count      = 0;
        setting_count      = 0;
        rand_count         = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset limit, reserved frames, zero lengths, repeat frees, top frame
        send_request(KIND_ALLOC_ONE, 15'h7FFF, 16'hFFFF);
        send_request(KIND_ALLOC_RUN, 15'd0, 16'd0);
        send_request(KIND_FREE_RUN, 15'd10, 16'd0);
        send_request(KIND_ALLOC_RUN, 15'd0, 16'd5);
        send_request(KIND_FREE_ONE, 15'd256, 16'hFFFF);
        send_request(KIND_FREE_ONE, 15'd256, 16'd0);
        send_request(KIND_ALLOC_RUN, 15'd0, 16'hFFFF);
        send_request(KIND_ALLOC_RUN, 15'd0, 16'd32768);
        send_request(KIND_FREE_RUN, 15'd0, 16'hFFFF);
        send_request(KIND_FREE_ONE, 15'd0, 16'd1);
        send_request(KIND_ALLOC_RUN, 15'd0, 16'd32768);
        send_request(KIND_ALLOC_ONE, 15'd0, 16'd0);
        send_request(KIND_FREE_ONE, 15'h7FFF, 16'd0);
        send_request(KIND_ALLOC_ONE, 15'd0, 16'd0);
        send_request(KIND_FREE_RUN, 15'h7FFF, 16'd2);
        send_request(KIND_FREE_RUN, 15'd32760, 16'd8);
        send_request(KIND_ALLOC_RUN, 15'd0, 16'd8);

        // Zero limit: everything fails and frees are ignored
        set_frames_total(16'd0);
        send_request(KIND_ALLOC_ONE, 15'd0, 16'd0);
        send_request(KIND_FREE_ONE, 15'd5, 16'd0);
        send_request(KIND_FREE_RUN, 15'd0, 16'd100);

        // Single frame limit
        set_frames_total(16'd1);
        send_request(KIND_FREE_RUN, 15'd0, 16'd3);
        send_request(KIND_ALLOC_ONE, 15'd0, 16'd0);
        send_request(KIND_ALLOC_ONE, 15'd0, 16'd0);

        // Oversized limit acts as the full bitmap
        set_frames_total(16'hFFFF);
        send_request(KIND_FREE_RUN, 15'd0, 16'd32768);
        send_request(KIND_ALLOC_RUN, 15'd0, 16'd32768);
        send_request(KIND_FREE_RUN, 15'd0, 16'hFFFF);

        // Random phases over several limits, idling phase advancing every dozen
        foreach (phase_totals[p]) begin
            set_frames_total(CFG_W'(phase_totals[p]));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idle_mode = t_idle_mode'((rand_count / 12) % 4);
                if (n == PHASE_ITEMS / 2 && (p % 3) == 1) drain_responses();
                send_random_request(phase_totals[p]);
                rand_count++;
            end
        end

        // Drain, then watch for stray responses
        drain_responses();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests over %0d frames_total settings (0, 1 and above the bitmap)",
                 request_count, setting_count);
        $display("Checked %0d responses under all four idling phases", checked);
        if (mismatch_count == 0) begin
            $display("PASS page_frame_bitmap_allocator");
        end else begin
            $display("FAIL page_frame_bitmap_allocator");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/pfba_pkg.sv
hdl/pfba_req_if.sv
hdl/pfba_rsp_if.sv
hdl/pfba_run_scan.sv
hdl/page_frame_bitmap_allocator.sv
hdl/pfba_checker.sv
verif/pfba_outcome_checker.sv
verif/page_frame_bitmap_allocator_tb.sv
